/* src/mssc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mssc_pkg;

  // Data store geometry
  localparam int DATA_WORDS = 256;
  localparam int DIDX_W     = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
  localparam int WCNT_W     = $clog2(DATA_WORDS + 1);

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_PC  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_BASE = CFG_IDX_W'(1);

  localparam logic [31:0] START_PC_RESET  = 32'h0040_0000;
  localparam logic [31:0] DATA_BASE_RESET = 32'h1000_0000;

  // Request types
  localparam logic [1:0] REQ_EXEC    = 2'd0;
  localparam logic [1:0] REQ_PRELOAD = 2'd1;
  localparam logic [1:0] REQ_READ    = 2'd2;

  // Primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTIU   = 6'h0b;
  localparam logic [5:0] OP_ANDI    = 6'h0c;
  localparam logic [5:0] OP_ORI     = 6'h0d;
  localparam logic [5:0] OP_LUI     = 6'h0f;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SW      = 6'h2b;

  // Function codes under OP_SPECIAL
  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLTU = 6'h2b;

  localparam logic [4:0] REG_RA = 5'd31;

  typedef struct packed {
    logic        en;
    logic [4:0]  addr;
    logic [31:0] data;
  } rf_wr_t;

endpackage

`default_nettype wire

/* src/mssc_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface mssc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] instruction;
  logic [31:0] preload_word;
  logic [7:0]  word_index;

  modport source (output valid, output req_type, output instruction,
                  output preload_word, output word_index, input ready);
  modport sink   (input valid, input req_type, input instruction,
                  input preload_word, input word_index, output ready);
endinterface

`default_nettype wire

/* src/mssc_res_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface mssc_res_if;
  logic               valid;
  logic               ready;
  logic [31:0]        next_pc;
  logic               reg_write;
  logic [4:0]         reg_number;
  logic signed [31:0] reg_value;
  logic               mem_write;
  logic [31:0]        mem_address;
  logic [31:0]        mem_value;
  logic [31:0]        read_word;
  logic               unknown_op;

  modport source (output valid, output next_pc, output reg_write, output reg_number,
                  output reg_value, output mem_write, output mem_address,
                  output mem_value, output read_word, output unknown_op, input ready);
  modport sink   (input valid, input next_pc, input reg_write, input reg_number,
                  input reg_value, input mem_write, input mem_address,
                  input mem_value, input read_word, input unknown_op, output ready);
endinterface

`default_nettype wire

/* src/mssc_cfg_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface mssc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mssc_pkg::CFG_IDX_W-1:0] index;
  logic [31:0]                    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* src/mssc_regfile.sv */
`timescale 1ns / 1ps
`default_nettype none

// 32 x 32 register file, two registered read ports, one write port.
// Entries not yet written since reset read as zero.
module mssc_regfile (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            rd_en,
  input  wire logic [4:0]      rd_addr_a,
  input  wire logic [4:0]      rd_addr_b,
  output logic [31:0]          rd_data_a,
  output logic [31:0]          rd_data_b,
  input  wire mssc_pkg::rf_wr_t wr
);

  logic [31:0] mem [32];
  logic [31:0] written;

  logic [31:0] q_a, q_b;
  logic        vld_a, vld_b;
  logic        byp_a, byp_b;
  logic [31:0] byp_val;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      q_a     <= mem[rd_addr_a];
      q_b     <= mem[rd_addr_b];
      vld_a   <= written[rd_addr_a];
      vld_b   <= written[rd_addr_b];
      // a write in the same cycle wins over the old array contents
      byp_a   <= wr.en && (wr.addr == rd_addr_a);
      byp_b   <= wr.en && (wr.addr == rd_addr_b);
      byp_val <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr.en) begin
      written[wr.addr] <= 1'b1;
    end
  end

  assign rd_data_a = byp_a ? byp_val : (vld_a ? q_a : 32'd0);
  assign rd_data_b = byp_b ? byp_val : (vld_b ? q_b : 32'd0);

endmodule

`default_nettype wire

/* src/mips_subset_single_cycle_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  Modport  Transfer carries
// -------  -------  ----------------------------------------------------------
// req      sink     req_type, instruction, preload_word, word_index
// res      source   next_pc, reg_write/number/value, mem_write/address/value,
//                   read_word, unknown_op
// cfg      sink     index, data (0: start_pc, 1: data_base); always ready
//
// One request per cycle sustained while res is ready; path is A, B, result register.
// Stage A executes against the register file read in the accept cycle, with
// forwarding from stage B; stage B finishes loads and store merges from the
// data store read issued at the A to B step, then the result register holds.
// Reset: PC = 0x00400000, registers zero, store empty. No clearing pass.
// A stalled result holds; bubbles ahead of it still fill, so req stays ready
// until all three stages hold requests.
module mips_subset_single_cycle_core (
  input  wire logic  clk,
  input  wire logic  rst,
  mssc_req_if.sink   req,
  mssc_res_if.source res,
  mssc_cfg_if.sink   cfg
);

  // ---------------------------------------------------------------- control
  logic req_xfer, a_adv, b_adv;
  logic a_valid, b_valid, c_valid;

  assign b_adv    = b_valid && (!c_valid || res.ready);
  assign a_adv    = a_valid && (!b_valid || b_adv);
  assign req.ready = !a_valid || a_adv;
  assign req_xfer = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (req_xfer) a_valid <= 1'b1;
      else if (a_adv) a_valid <= 1'b0;
      if (a_adv) b_valid <= 1'b1;
      else if (b_adv) b_valid <= 1'b0;
      if (b_adv) c_valid <= 1'b1;
      else if (res.ready) c_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- state
  logic [31:0]                 pc;
  logic [31:0]                 data_base;
  logic [mssc_pkg::WCNT_W-1:0] words_loaded;
  logic                        store_full;

  assign store_full = (words_loaded == mssc_pkg::WCNT_W'(mssc_pkg::DATA_WORDS));

  // ---------------------------------------------------------------- stage A
  logic [1:0]  a_req;
  logic [31:0] a_ins;
  logic [31:0] a_preload;
  logic [7:0]  a_widx;

  always_ff @(posedge clk) begin
    if (req_xfer) begin
      a_req     <= req.req_type;
      a_ins     <= req.instruction;
      a_preload <= req.preload_word;
      a_widx    <= req.word_index;
    end
  end

  mssc_pkg::rf_wr_t rf_wr;
  logic [31:0]      rf_a, rf_b;

  mssc_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (req_xfer),
    .rd_addr_a (req.instruction[25:21]),
    .rd_addr_b (req.instruction[20:16]),
    .rd_data_a (rf_a),
    .rd_data_b (rf_b),
    .wr        (rf_wr)
  );

  // stage B signals needed for forwarding
  logic        b_rwr;
  logic [4:0]  b_dest;
  logic [31:0] b_rval_fin;

  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd, sh;
  logic [31:0] simm, zimm;
  logic [31:0] opa, opb, pc4;
  logic [31:0] ls_addr, ls_off;
  logic [29:0] ls_word;
  logic [31:0] ls_word_ext, widx_ext, wcnt_ext;
  logic        ls_hit, rd_hit;

  logic [31:0]                 x_npc, x_val, x_maddr;
  logic [4:0]                  x_dest;
  logic                        x_wr, x_ld, x_lb, x_st, x_sb, x_unk, x_pl, x_rd;
  logic [mssc_pkg::DIDX_W-1:0] x_didx;

  assign op   = a_ins[31:26];
  assign rs   = a_ins[25:21];
  assign rt   = a_ins[20:16];
  assign rd   = a_ins[15:11];
  assign sh   = a_ins[10:6];
  assign fn   = a_ins[5:0];
  assign zimm = {16'd0, a_ins[15:0]};
  assign simm = {{16{a_ins[15]}}, a_ins[15:0]};

  // an older request still in stage B has not yet written the register file
  assign opa = (b_valid && b_rwr && (b_dest == rs)) ? b_rval_fin : rf_a;
  assign opb = (b_valid && b_rwr && (b_dest == rt)) ? b_rval_fin : rf_b;
  assign pc4 = pc + 32'd4;

  // full byte offset first: data_base need not be word aligned
  assign ls_addr     = opa + simm;
  assign ls_off      = {ls_addr[31:2], 2'b00} - data_base;
  assign ls_word     = ls_off[31:2];
  assign ls_word_ext = {2'b00, ls_word};
  assign wcnt_ext    = 32'(words_loaded);
  assign widx_ext    = 32'(a_widx);
  assign ls_hit      = ls_word_ext < wcnt_ext;
  assign rd_hit      = widx_ext < wcnt_ext;

  always_comb begin
    x_npc   = pc;
    x_val   = 32'd0;
    x_maddr = 32'd0;
    x_dest  = 5'd0;
    x_wr    = 1'b0;
    x_ld    = 1'b0;
    x_lb    = 1'b0;
    x_st    = 1'b0;
    x_sb    = 1'b0;
    x_unk   = 1'b0;
    x_pl    = 1'b0;
    x_rd    = 1'b0;
    x_didx  = ls_word_ext[mssc_pkg::DIDX_W-1:0];
    unique case (a_req)
      mssc_pkg::REQ_EXEC: begin
        x_npc = pc4;
        unique case (op)
          mssc_pkg::OP_SPECIAL: begin
            x_dest = rd;
            x_wr   = 1'b1;
            unique case (fn)
              mssc_pkg::FN_ADDU: x_val = opa + opb;
              mssc_pkg::FN_SUBU: x_val = opa - opb;
              mssc_pkg::FN_AND:  x_val = opa & opb;
              mssc_pkg::FN_OR:   x_val = opa | opb;
              mssc_pkg::FN_NOR:  x_val = ~(opa | opb);
              mssc_pkg::FN_SLTU: x_val = {31'd0, opa < opb};
              mssc_pkg::FN_SLL:  x_val = opb << sh;
              mssc_pkg::FN_SRL:  x_val = opb >> sh;
              mssc_pkg::FN_JR: begin
                x_wr  = 1'b0;
                x_npc = opa;
              end
              default: begin
                x_wr  = 1'b0;
                x_unk = 1'b1;
              end
            endcase
          end
          mssc_pkg::OP_ADDIU: begin
            x_dest = rt; x_wr = 1'b1; x_val = opa + simm;
          end
          mssc_pkg::OP_ANDI: begin
            x_dest = rt; x_wr = 1'b1; x_val = opa & zimm;
          end
          mssc_pkg::OP_ORI: begin
            x_dest = rt; x_wr = 1'b1; x_val = opa | zimm;
          end
          mssc_pkg::OP_LUI: begin
            x_dest = rt; x_wr = 1'b1; x_val = {a_ins[15:0], 16'd0};
          end
          mssc_pkg::OP_SLTIU: begin
            x_dest = rt; x_wr = 1'b1; x_val = {31'd0, opa < simm};
          end
          mssc_pkg::OP_LW, mssc_pkg::OP_LB: begin
            x_maddr = {ls_addr[31:2], 2'b00};
            x_dest  = rt;
            x_wr    = ls_hit;
            x_ld    = ls_hit;
            x_lb    = (op == mssc_pkg::OP_LB);
          end
          mssc_pkg::OP_SW, mssc_pkg::OP_SB: begin
            x_maddr = {ls_addr[31:2], 2'b00};
            x_st    = ls_hit;
            x_sb    = (op == mssc_pkg::OP_SB);
          end
          mssc_pkg::OP_BEQ, mssc_pkg::OP_BNE: begin
            if ((op == mssc_pkg::OP_BEQ) == (opa == opb)) begin
              x_npc = pc4 + {simm[29:0], 2'b00};
            end
          end
          mssc_pkg::OP_J, mssc_pkg::OP_JAL: begin
            x_npc = {pc4[31:28], a_ins[25:0], 2'b00};
            if (op == mssc_pkg::OP_JAL) begin
              x_dest = mssc_pkg::REG_RA;
              x_wr   = 1'b1;
              x_val  = pc4;
            end
          end
          default: x_unk = 1'b1;
        endcase
      end
      mssc_pkg::REQ_PRELOAD: begin
        x_pl   = !store_full;
        x_didx = wcnt_ext[mssc_pkg::DIDX_W-1:0];
      end
      mssc_pkg::REQ_READ: begin
        x_rd   = rd_hit;
        x_didx = widx_ext[mssc_pkg::DIDX_W-1:0];
      end
      default: ;
    endcase
  end

  logic x_rwr;
  assign x_rwr = x_wr && (x_dest != 5'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc           <= mssc_pkg::START_PC_RESET;
      data_base    <= mssc_pkg::DATA_BASE_RESET;
      words_loaded <= '0;
    end else begin
      if (a_adv) begin
        pc <= x_npc;
        if (x_pl) words_loaded <= words_loaded + 1'b1;
      end
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == mssc_pkg::CFG_START_PC)  pc        <= cfg.data;
        if (cfg.index == mssc_pkg::CFG_DATA_BASE) data_base <= cfg.data;
      end
    end
  end

  // ---------------------------------------------------------------- stage B
  logic [31:0]                 b_npc, b_rval, b_maddr, b_bval, b_plword;
  logic [1:0]                  b_boff;
  logic                        b_ld, b_lb, b_st, b_sb, b_unk, b_pl, b_rd;
  logic [mssc_pkg::DIDX_W-1:0] b_didx;

  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_npc    <= x_npc;
      b_rwr    <= x_rwr;
      b_dest   <= x_rwr ? x_dest : 5'd0;
      b_rval   <= x_val;
      b_maddr  <= x_maddr;
      b_bval   <= opb;
      b_plword <= a_preload;
      b_boff   <= ls_addr[1:0];
      b_ld     <= x_ld;
      b_lb     <= x_lb;
      b_st     <= x_st;
      b_sb     <= x_sb;
      b_unk    <= x_unk;
      b_pl     <= x_pl;
      b_rd     <= x_rd;
      b_didx   <= x_didx;
    end
  end

  // data store: read issued on the A to B step, written when B moves on
  logic [31:0]                 dstore [mssc_pkg::DATA_WORDS];
  logic [31:0]                 dm_q, dm_byp_val, dm_wdata, dm_word;
  logic                        dm_byp, dm_we;

  assign dm_we = b_adv && (b_st || b_pl);

  always_ff @(posedge clk) begin
    if (dm_we) begin
      dstore[b_didx] <= dm_wdata;
    end
    if (a_adv) begin
      dm_q       <= dstore[x_didx];
      dm_byp     <= dm_we && (b_didx == x_didx);
      dm_byp_val <= dm_wdata;
    end
  end

  assign dm_word = dm_byp ? dm_byp_val : dm_q;

  // big-endian: byte offset 0 is the most significant byte
  function automatic logic [31:0] load_byte(logic [31:0] w, logic [1:0] off);
    logic [7:0] by;
    unique case (off)
      2'd0: by = w[31:24];
      2'd1: by = w[23:16];
      2'd2: by = w[15:8];
      2'd3: by = w[7:0];
    endcase
    return {{24{by[7]}}, by};
  endfunction

  function automatic logic [31:0] merge_byte(logic [31:0] w, logic [7:0] by,
                                             logic [1:0] off);
    logic [31:0] r;
    r = w;
    unique case (off)
      2'd0: r[31:24] = by;
      2'd1: r[23:16] = by;
      2'd2: r[15:8]  = by;
      2'd3: r[7:0]   = by;
    endcase
    return r;
  endfunction

  logic [31:0] st_word;

  assign st_word    = b_sb ? merge_byte(dm_word, b_bval[7:0], b_boff) : b_bval;
  assign dm_wdata   = b_pl ? b_plword : st_word;
  assign b_rval_fin = b_ld ? (b_lb ? load_byte(dm_word, b_boff) : dm_word) : b_rval;

  assign rf_wr.en   = b_adv && b_rwr;
  assign rf_wr.addr = b_dest;
  assign rf_wr.data = b_rval_fin;

  // ---------------------------------------------------------------- result
  always_ff @(posedge clk) begin
    if (b_adv) begin
      res.next_pc     <= b_npc;
      res.reg_write   <= b_rwr;
      res.reg_number  <= b_dest;
      res.reg_value   <= $signed(b_rwr ? b_rval_fin : 32'd0);
      res.mem_write   <= b_st;
      res.mem_address <= b_maddr;
      res.mem_value   <= b_st ? st_word : 32'd0;
      res.read_word   <= b_rd ? dm_word : 32'd0;
      res.unknown_op  <= b_unk;
    end
  end

  assign res.valid = c_valid;

`ifndef SYNTHESIS
  a_no_r0_write: assert property (@(posedge clk) disable iff (rst)
    rf_wr.en |-> (rf_wr.addr != 5'd0))
    else $error("write to r0 reached the register file");

  a_store_no_reg: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.mem_write) |-> !res.reg_write)
    else $error("store result also reports a register write");

  a_stage_a_hold: assert property (@(posedge clk) disable iff (rst)
    (a_valid && !a_adv) |=> (a_valid && $stable(a_ins) && $stable(a_req)))
    else $error("stalled stage A request lost or changed");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    words_loaded <= mssc_pkg::WCNT_W'(mssc_pkg::DATA_WORDS))
    else $error("data store fill count beyond depth");
`endif

endmodule

`default_nettype wire
